FILE: rtl/whb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whb_pkg
// Types and constants shared by the water hydrogen-bond pair detector.
// ----------------------------------------------------------------------------
package whb_pkg;

  localparam int CoordW  = 20;             // signed Q10.10 coordinate
  localparam int BoxW    = 19;             // unsigned box length
  localparam int DistW   = 40;             // squared O-O cutoff
  localparam int CosW    = 17;             // cos^2 cutoff, Q1.16
  localparam int CosFrac = 16;
  localparam int IdxW    = 6;              // water_index / tag width
  localparam int MaskW   = 64;
  localparam int CfgIdxW = 3;
  localparam int PairLat = 7;              // pair unit latency in cycles

  localparam logic [BoxW-1:0]  BoxReset  = BoxW'(30720);
  localparam logic [DistW-1:0] DistReset = DistW'(12845056);
  localparam logic [CosW-1:0]  CosReset  = CosW'(49152);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBoxX    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxY    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBoxZ    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDistCut = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCosCut  = 3'd4;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    vec_t ox;
    vec_t oh1;
    vec_t oh2;
  } water_t;

  typedef struct packed {
    logic [2:0][BoxW-1:0] box;
    logic [DistW-1:0]     dist_cut;
    logic [CosW-1:0]      cos_cut;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] tag;
    water_t          rec;
  } pair_req_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] tag;
    logic            bond;
  } pair_rsp_t;

  typedef struct packed {
    logic                     start_frame;
    logic signed [CoordW-1:0] oxygen_x;
    logic signed [CoordW-1:0] oxygen_y;
    logic signed [CoordW-1:0] oxygen_z;
    logic signed [CoordW-1:0] hyd1_x;
    logic signed [CoordW-1:0] hyd1_y;
    logic signed [CoordW-1:0] hyd1_z;
    logic signed [CoordW-1:0] hyd2_x;
    logic signed [CoordW-1:0] hyd2_y;
    logic signed [CoordW-1:0] hyd2_z;
  } whb_in_t;

  typedef struct packed {
    logic [IdxW-1:0]  water_index;
    logic [MaskW-1:0] bond_mask;
    logic [IdxW-1:0]  bond_count;
    logic             overflow;
  } whb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // minimum image: one conditional box add/sub, then saturate
  function automatic coord_t min_img(logic signed [CoordW:0] d, logic [BoxW-1:0] box);
    logic signed [CoordW+2:0] de;
    logic signed [CoordW+2:0] d2;
    logic signed [CoordW+2:0] bx;
    logic signed [CoordW+2:0] r;
    de = (CoordW+3)'(d);
    d2 = de <<< 1;
    bx = $signed({{(CoordW+3-BoxW){1'b0}}, box});
    if (d2 >= bx) begin
      r = de - bx;
    end else if (d2 <= -bx) begin
      r = de + bx;
    end else begin
      r = de;
    end
    if (r[CoordW+2:CoordW-1] == '0 || r[CoordW+2:CoordW-1] == '1) begin
      min_img = r[CoordW-1:0];
    end else if (r[CoordW+2]) begin
      min_img = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      min_img = {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/whb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whb_cell
// One storage cell of the water ring; shifts to its neighbor or loads.
// ----------------------------------------------------------------------------
module whb_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  whb_pkg::water_t shift_in,
  input  logic            load_en,
  input  whb_pkg::water_t load_data,
  output whb_pkg::water_t q
);
  import whb_pkg::*;

  water_t q_r;

  always_ff @(posedge clk) begin
    if (load_en) begin
      q_r <= load_data;
    end else if (shift_en) begin
      q_r <= shift_in;
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/whb_pair_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whb_pair_unit
// Pipelined pair test: O-O range plus four exact angle tests.
// ----------------------------------------------------------------------------
module whb_pair_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  whb_pkg::pair_req_t req,
  input  whb_pkg::water_t    nw,
  input  whb_pkg::cfg_t      cfg,
  output whb_pkg::pair_rsp_t rsp
);
  import whb_pkg::*;

  localparam int HW  = CoordW;          // split width
  localparam int SW  = 2 * CoordW;      // products / sums of squares
  localparam int PW  = 2 * SW;          // squared sums
  localparam int NCH = PW / HW;
  localparam int LW  = PW + CosFrac;
  localparam int RW  = PW + CosW;

  logic [PairLat-1:0]           v_r;
  logic [PairLat-1:0][IdxW-1:0] tag_r;

  // stage 1
  coord_t s1_d_r [3];
  vec_t   s1_h_r [2];
  coord_t s1_d_nxt [3];
  // stage 2
  logic        [SW-1:0] sqd_r [3];
  logic signed [SW-1:0] pd_r  [4][3];
  logic        [SW-1:0] sqh_r [4][3];
  logic signed [SW-1:0] sqd_nxt [3];
  logic signed [SW-1:0] pd_nxt  [4][3];
  logic signed [SW-1:0] sqh_nxt [4][3];
  coord_t               hsel [4][3];
  // stage 3
  logic        [SW-1:0] roo2_r;
  logic signed [SW:0]   dot_r [4];
  logic        [SW-1:0] oh2_r [4];
  logic signed [SW:0]   dsum [4];
  // stage 4
  logic                 inr4_r;
  logic [3:0]           pos4_r;
  logic [2*HW-1:0]      dhh_r [4];
  logic [2*HW-1:0]      dhl_r [4];
  logic [2*HW-1:0]      dll_r [4];
  logic [2*HW-1:0]      phh_r [4];
  logic [2*HW-1:0]      phl_r [4];
  logic [2*HW-1:0]      plh_r [4];
  logic [2*HW-1:0]      pll_r [4];
  // stage 5
  logic                 inr5_r;
  logic [3:0]           pos5_r;
  logic [PW-1:0]        dsq_r [4];
  logic [PW-1:0]        pr_r  [4];
  // stage 6
  logic                 inr6_r;
  logic [3:0]           pos6_r;
  logic [LW-1:0]        lhs_r [4];
  logic [HW+CosW-1:0]   pc_r  [4][NCH];
  // stage 7
  logic                 bond_r;
  logic [RW-1:0]        rhs [4];
  logic [3:0]           ok;

  // valid / tag pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[PairLat-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= {tag_r[PairLat-2:0], req.tag};
  end

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      s1_d_nxt[n] = min_img((CoordW+1)'($signed(nw.ox[n])) -
                            (CoordW+1)'($signed(req.rec.ox[n])), cfg.box[n]);
    end
  end

  always_ff @(posedge clk) begin
    s1_d_r   <= s1_d_nxt;
    s1_h_r[0] <= req.rec.oh1;
    s1_h_r[1] <= req.rec.oh2;
  end

  // lanes 0,1: stored hydrogens; lanes 2,3: new hydrogens (vector flipped)
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      hsel[0][n] = $signed(s1_h_r[0][n]);
      hsel[1][n] = $signed(s1_h_r[1][n]);
      hsel[2][n] = $signed(nw.oh1[n]);
      hsel[3][n] = $signed(nw.oh2[n]);
      sqd_nxt[n] = s1_d_r[n] * s1_d_r[n];
      for (int l = 0; l < 4; l++) begin
        pd_nxt[l][n]  = hsel[l][n] * s1_d_r[n];
        sqh_nxt[l][n] = hsel[l][n] * hsel[l][n];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int n = 0; n < 3; n++) begin
      sqd_r[n] <= sqd_nxt[n];
      for (int l = 0; l < 4; l++) begin
        pd_r[l][n]  <= pd_nxt[l][n];
        sqh_r[l][n] <= sqh_nxt[l][n];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dsum[l] = (SW+1)'(pd_r[l][0]) + (SW+1)'(pd_r[l][1]) + (SW+1)'(pd_r[l][2]);
    end
  end

  always_ff @(posedge clk) begin
    roo2_r <= sqd_r[0] + sqd_r[1] + sqd_r[2];
    for (int l = 0; l < 4; l++) begin
      dot_r[l] <= (l >= 2) ? -dsum[l] : dsum[l];
      oh2_r[l] <= sqh_r[l][0] + sqh_r[l][1] + sqh_r[l][2];
    end
  end

  // split 40x40 products into 20x20 partials
  always_ff @(posedge clk) begin
    inr4_r <= (roo2_r <= cfg.dist_cut);
    for (int l = 0; l < 4; l++) begin
      pos4_r[l] <= !dot_r[l][SW] && (dot_r[l] != '0);
      dhh_r[l]  <= dot_r[l][SW-1:HW] * dot_r[l][SW-1:HW];
      dhl_r[l]  <= dot_r[l][SW-1:HW] * dot_r[l][HW-1:0];
      dll_r[l]  <= dot_r[l][HW-1:0]  * dot_r[l][HW-1:0];
      phh_r[l]  <= oh2_r[l][SW-1:HW] * roo2_r[SW-1:HW];
      phl_r[l]  <= oh2_r[l][SW-1:HW] * roo2_r[HW-1:0];
      plh_r[l]  <= oh2_r[l][HW-1:0]  * roo2_r[SW-1:HW];
      pll_r[l]  <= oh2_r[l][HW-1:0]  * roo2_r[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    inr5_r <= inr4_r;
    pos5_r <= pos4_r;
    for (int l = 0; l < 4; l++) begin
      dsq_r[l] <= (PW'(dhh_r[l]) << (2*HW)) + (PW'(dhl_r[l]) << (HW+1)) + PW'(dll_r[l]);
      pr_r[l]  <= (PW'(phh_r[l]) << (2*HW)) + (PW'(phl_r[l]) << HW) +
                  (PW'(plh_r[l]) << HW) + PW'(pll_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    inr6_r <= inr5_r;
    pos6_r <= pos5_r;
    for (int l = 0; l < 4; l++) begin
      lhs_r[l] <= LW'(dsq_r[l]) << CosFrac;
      for (int j = 0; j < NCH; j++) begin
        pc_r[l][j] <= pr_r[l][HW*j +: HW] * cfg.cos_cut;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rhs[l] = '0;
      for (int j = 0; j < NCH; j++) begin
        rhs[l] = rhs[l] + (RW'(pc_r[l][j]) << (HW*j));
      end
      ok[l] = pos6_r[l] && (RW'(lhs_r[l]) >= rhs[l]);
    end
  end

  always_ff @(posedge clk) begin
    bond_r <= inr6_r && (ok != '0);
  end

  assign rsp.valid = v_r[PairLat-1];
  assign rsp.tag   = tag_r[PairLat-1];
  assign rsp.bond  = bond_r;

endmodule

FILE: rtl/water_hbond_pair_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// water_hbond_pair_detector
// Geometric water hydrogen-bond detector: one water per transaction, one
// bond row per transaction.
// ----------------------------------------------------------------------------
//  channel | ports                               | handshake
//  --------+-------------------------------------+------------------------------
//  input   | start, busy, in_data                | taken when start & !busy
//  result  | out_strobe, out_data                | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_wdata        | written when cfg_we
//
//  In each transaction the stored waters rotate once around the cell ring,
//  one pair test per cycle through the shared pair unit, then the unit
//  drains. An overflow transaction (store full) skips the scan and drain.
//  Reset (rst_n low, synchronous) empties the frame and loads the default
//  box and cutoffs; the ring contents are not cleared.
//  The result strobe cannot be held off; busy stays high until it is given.
// ----------------------------------------------------------------------------
module water_hbond_pair_detector #(
  parameter int MAX_WATERS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  whb_pkg::whb_in_t              in_data,
  output logic                          out_strobe,
  output whb_pkg::whb_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [whb_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [whb_pkg::DistW-1:0]     cfg_wdata
);
  import whb_pkg::*;

  localparam int IW   = (MAX_WATERS > 1) ? $clog2(MAX_WATERS) : 1;
  localparam int CNTW = $clog2(MAX_WATERS + 1);
  localparam int DRW  = $clog2(PairLat);

  // configuration
  cfg_t cfg_r;

  // control
  state_t          state_r, state_nxt;
  logic [CNTW-1:0] count_r;        // waters stored in this frame
  logic [IW-1:0]   k_r;            // ring step / slot under test
  logic [DRW-1:0]  dr_r;           // drain counter
  logic            ovf_r;
  logic [MaskW-1:0] mask_r;
  logic [IdxW-1:0] bcnt_r;

  // new water, hydrogens already in minimum-image O-H form
  water_t          nw_r;
  water_t          nw_nxt;
  logic [CNTW-1:0] cnt_eff;

  // FSM outputs
  logic rotate;
  logic feed;
  logic load_go;

  // ring
  water_t    cell_q [MAX_WATERS];
  pair_req_t req;
  pair_rsp_t rsp;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box      <= {BoxReset, BoxReset, BoxReset};
      cfg_r.dist_cut <= DistReset;
      cfg_r.cos_cut  <= CosReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgBoxX:    cfg_r.box[0]   <= cfg_wdata[BoxW-1:0];
        CfgBoxY:    cfg_r.box[1]   <= cfg_wdata[BoxW-1:0];
        CfgBoxZ:    cfg_r.box[2]   <= cfg_wdata[BoxW-1:0];
        CfgDistCut: cfg_r.dist_cut <= cfg_wdata;
        CfgCosCut:  cfg_r.cos_cut  <= cfg_wdata[CosW-1:0];
        default:    ;
      endcase
    end
  end

  // ---- capture of the incoming water ----
  always_comb begin
    nw_nxt.ox[0]  = in_data.oxygen_x;
    nw_nxt.ox[1]  = in_data.oxygen_y;
    nw_nxt.ox[2]  = in_data.oxygen_z;
    nw_nxt.oh1[0] = min_img((CoordW+1)'(in_data.hyd1_x) - (CoordW+1)'(in_data.oxygen_x),
                            cfg_r.box[0]);
    nw_nxt.oh1[1] = min_img((CoordW+1)'(in_data.hyd1_y) - (CoordW+1)'(in_data.oxygen_y),
                            cfg_r.box[1]);
    nw_nxt.oh1[2] = min_img((CoordW+1)'(in_data.hyd1_z) - (CoordW+1)'(in_data.oxygen_z),
                            cfg_r.box[2]);
    nw_nxt.oh2[0] = min_img((CoordW+1)'(in_data.hyd2_x) - (CoordW+1)'(in_data.oxygen_x),
                            cfg_r.box[0]);
    nw_nxt.oh2[1] = min_img((CoordW+1)'(in_data.hyd2_y) - (CoordW+1)'(in_data.oxygen_y),
                            cfg_r.box[1]);
    nw_nxt.oh2[2] = min_img((CoordW+1)'(in_data.hyd2_z) - (CoordW+1)'(in_data.oxygen_z),
                            cfg_r.box[2]);
    cnt_eff = in_data.start_frame ? '0 : count_r;
  end

  // ---- state machine ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b1;
    rotate     = 1'b0;
    feed       = 1'b0;
    load_go    = 1'b0;
    out_strobe = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = (cnt_eff >= CNTW'(MAX_WATERS)) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // slot k_r sits at the ring head this cycle
        rotate = 1'b1;
        feed   = (CNTW'(k_r) < count_r);
        if (k_r == IW'(MAX_WATERS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dr_r == DRW'(PairLat - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        out_strobe = 1'b1;
        load_go    = !ovf_r;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- control counters ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
      dr_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (state_r == ST_IDLE && start) begin
        count_r <= cnt_eff;
        ovf_r   <= (cnt_eff >= CNTW'(MAX_WATERS));
        k_r     <= '0;
        dr_r    <= '0;
      end
      if (state_r == ST_SCAN) begin
        k_r <= k_r + 1'b1;
      end
      if (state_r == ST_DRAIN) begin
        dr_r <= dr_r + 1'b1;
      end
      if (load_go) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // ---- bond row accumulation ----
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      nw_r   <= nw_nxt;
      mask_r <= '0;
      bcnt_r <= '0;
    end else if (rsp.valid && rsp.bond) begin
      mask_r[rsp.tag] <= 1'b1;
      bcnt_r          <= bcnt_r + 1'b1;
    end
  end

  // ---- cell ring: cell i takes cell i+1, the last takes the head ----
  for (genvar i = 0; i < MAX_WATERS; i++) begin : g_ring
    localparam int Nx = (i + 1) % MAX_WATERS;
    whb_cell u_cell (
      .clk       (clk),
      .shift_en  (rotate),
      .shift_in  (cell_q[Nx]),
      .load_en   (load_go && (count_r == CNTW'(i))),
      .load_data (nw_r),
      .q         (cell_q[i])
    );
  end

  // ---- shared pair unit fed from the ring head ----
  assign req.valid = feed;
  assign req.tag   = IdxW'(k_r);
  assign req.rec   = cell_q[0];

  whb_pair_unit u_pair (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .nw    (nw_r),
    .cfg   (cfg_r),
    .rsp   (rsp)
  );

  // ---- result transaction ----
  assign out_data.water_index = ovf_r ? '0 : IdxW'(count_r);
  assign out_data.bond_mask   = ovf_r ? '0 : mask_r;
  assign out_data.bond_count  = ovf_r ? '0 : bcnt_r;
  assign out_data.overflow    = ovf_r;

endmodule

FILE: tb/sv/whb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whb_checker
// Watches the input, result and register channels of the hydrogen-bond
// detector, predicts each bond row and compares it with what comes out.
// ----------------------------------------------------------------------------
module whb_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  whb_pkg::whb_in_t             in_data,
  input  logic                         out_strobe,
  input  whb_pkg::whb_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [whb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [whb_pkg::DistW-1:0]    cfg_wdata,
  output int                           err_count,
  output int                           pending,
  output int                           rows_seen,
  output int                           bonded_rows,
  output int                           overflow_rows
);
  import whb_pkg::*;

  localparam int Slots = 64;
  localparam longint CoordMax = (longint'(1) << (CoordW - 1)) - 1;

  typedef longint vec3_t [3];

  logic [BoxW-1:0]  box_len [3];
  logic [DistW-1:0] roo_cut;
  logic [CosW-1:0]  cos_cut;
  vec3_t            oxy_store [Slots];
  vec3_t            oh1_store [Slots];
  vec3_t            oh2_store [Slots];
  int               frame_waters;
  whb_out_t         row_queue [$];

  assign pending = row_queue.size();

  function automatic longint wrap_axis(longint d, logic [BoxW-1:0] b);
    longint bl;
    bl = longint'(b);
    if (2 * d >= bl) d = d - bl;
    else if (2 * d <= -bl) d = d + bl;
    if (d > CoordMax) d = CoordMax;
    if (d < -CoordMax - 1) d = -CoordMax - 1;
    return d;
  endfunction

  // exact angle test; flip points the O-O vector the other way
  function automatic bit angle_pass(vec3_t h, vec3_t d, bit flip, longint roo2);
    longint      dot;
    longint      oh_sq;
    logic [127:0] lhs;
    logic [127:0] rhs;
    dot = 0;
    oh_sq = 0;
    for (int n = 0; n < 3; n++) begin
      dot += h[n] * d[n];
      oh_sq += h[n] * h[n];
    end
    if (flip) dot = -dot;
    if (dot <= 0) return 1'b0;
    lhs = (128'(dot) * 128'(dot)) << CosFrac;
    rhs = 128'(cos_cut) * 128'(oh_sq) * 128'(roo2);
    return lhs >= rhs;
  endfunction

  function automatic whb_out_t bond_row(whb_in_t w);
    whb_out_t r;
    vec3_t    ox, h1, h2, d;
    longint   hy1 [3];
    longint   hy2 [3];
    longint   roo2;
    r = '0;
    ox[0] = longint'(w.oxygen_x); ox[1] = longint'(w.oxygen_y); ox[2] = longint'(w.oxygen_z);
    hy1[0] = longint'(w.hyd1_x); hy1[1] = longint'(w.hyd1_y); hy1[2] = longint'(w.hyd1_z);
    hy2[0] = longint'(w.hyd2_x); hy2[1] = longint'(w.hyd2_y); hy2[2] = longint'(w.hyd2_z);
    if (w.start_frame) frame_waters = 0;
    for (int n = 0; n < 3; n++) begin
      h1[n] = wrap_axis(hy1[n] - ox[n], box_len[n]);
      h2[n] = wrap_axis(hy2[n] - ox[n], box_len[n]);
    end
    if (frame_waters >= Slots) begin
      r.overflow = 1'b1;
      return r;
    end
    for (int k = 0; k < frame_waters; k++) begin
      roo2 = 0;
      for (int n = 0; n < 3; n++) begin
        d[n] = wrap_axis(ox[n] - oxy_store[k][n], box_len[n]);
        roo2 += d[n] * d[n];
      end
      if (roo2 > longint'(roo_cut)) continue;
      if (angle_pass(oh1_store[k], d, 1'b0, roo2) || angle_pass(oh2_store[k], d, 1'b0, roo2) ||
          angle_pass(h1, d, 1'b1, roo2) || angle_pass(h2, d, 1'b1, roo2)) begin
        r.bond_mask[k] = 1'b1;
        r.bond_count = r.bond_count + 1'b1;
      end
    end
    oxy_store[frame_waters] = ox;
    oh1_store[frame_waters] = h1;
    oh2_store[frame_waters] = h2;
    r.water_index = frame_waters[IdxW-1:0];
    frame_waters++;
    return r;
  endfunction

  initial begin
    err_count = 0;
    rows_seen = 0;
    bonded_rows = 0;
    overflow_rows = 0;
  end

  always @(posedge clk) begin
    whb_out_t want;
    if (!rst_n) begin
      box_len[0] = BoxReset;
      box_len[1] = BoxReset;
      box_len[2] = BoxReset;
      roo_cut = DistReset;
      cos_cut = CosReset;
      frame_waters = 0;
      row_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgBoxX:    box_len[0] = cfg_wdata[BoxW-1:0];
          CfgBoxY:    box_len[1] = cfg_wdata[BoxW-1:0];
          CfgBoxZ:    box_len[2] = cfg_wdata[BoxW-1:0];
          CfgDistCut: roo_cut = cfg_wdata;
          CfgCosCut:  cos_cut = cfg_wdata[CosW-1:0];
          default: ;
        endcase
      end
      if (out_strobe) begin
        rows_seen++;
        if (row_queue.size() == 0) begin
          err_count++;
          $display("%0t: unexpected row, actual %p", $time, out_data);
        end else begin
          want = row_queue.pop_front();
          if (want !== out_data) begin
            err_count++;
            $display("%0t: row mismatch", $time);
            $display("  expected idx %0d mask %h count %0d ovf %b", want.water_index,
                     want.bond_mask, want.bond_count, want.overflow);
            $display("  actual   idx %0d mask %h count %0d ovf %b", out_data.water_index,
                     out_data.bond_mask, out_data.bond_count, out_data.overflow);
          end
          if (want.bond_count != 0) bonded_rows++;
          if (want.overflow) overflow_rows++;
        end
      end
      if (start && !busy) row_queue.insert(row_queue.size(), bond_row(in_data));
    end
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the water hydrogen-bond pair detector: directed waters,
// then frames of clustered waters with random content under several box and
// cutoff settings and sender idle rates; a checker predicts every bond row.
// ----------------------------------------------------------------------------
module tb;
  import whb_pkg::*;

  localparam int PhaseCount = 8;
  localparam int PhaseItems = 230;        // ~1850 random transactions total
  localparam int CycleLimit = 3000000;    // ~20x the slowest expected run

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  whb_in_t            in_data = '0;
  logic               out_strobe;
  whb_out_t           out_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgBoxX;
  logic [DistW-1:0]   cfg_wdata = '0;

  int err_count, pending, rows_seen, bonded_rows, overflow_rows;
  int cycles = 0;
  int idle_pct = 0;
  int sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  water_hbond_pair_detector dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  whb_checker chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata,
    .err_count, .pending, .rows_seen, .bonded_rows, .overflow_rows
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // one input transaction; optional idle gap first, then hold start until taken
  task automatic send_water(whb_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  // registers only change with the block quiet and all rows delivered
  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (PairLat + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_setting(int sel);
    logic [BoxW-1:0]  bx, by, bz;
    logic [DistW-1:0] dc;
    logic [CosW-1:0]  cc;
    case (sel)
      1: begin bx = '1; by = '1; bz = '1; dc = '1; cc = CosW'(65536); end
      2: begin bx = 19'd1; by = 19'd1; bz = 19'd1; dc = '0; cc = '0; end
      3: begin
        bx = 19'd20000; by = 19'd25000; bz = 19'd30720; dc = 40'd20000000; cc = '1;
      end
      4: begin bx = '0; by = 19'd12345; bz = '0; dc = 40'hFF_FFFF_FFFF; cc = 17'd1; end
      5: begin
        bx = BoxW'($urandom_range(8000, 60000)); by = BoxW'($urandom_range(8000, 60000));
        bz = BoxW'($urandom_range(8000, 60000));
        dc = DistW'($urandom_range(4000000, 30000000)); cc = CosW'($urandom_range(65536));
      end
      6: begin
        bx = 19'd4096; by = 19'd4096; bz = 19'd4096; dc = 40'd12845056; cc = 17'd32768;
      end
      default: begin bx = BoxReset; by = BoxReset; bz = BoxReset; dc = DistReset; cc = CosReset; end
    endcase
    write_reg(CfgBoxX, DistW'(bx));
    write_reg(CfgBoxY, DistW'(by));
    write_reg(CfgBoxZ, DistW'(bz));
    write_reg(CfgDistCut, dc);
    write_reg(CfgCosCut, DistW'(cc));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic coord_t near(int base, int spread);
    return coord_t'(base + $signed($urandom_range(2 * spread)) - spread);
  endfunction

  // water clustered around a center so that O-O pairs fall in range
  function automatic whb_in_t cluster_water(bit sf, int cx, int cy, int cz);
    whb_in_t w;
    w.start_frame = sf;
    w.oxygen_x = near(cx, 3000);
    w.oxygen_y = near(cy, 3000);
    w.oxygen_z = near(cz, 3000);
    w.hyd1_x = near(w.oxygen_x, 1100);
    w.hyd1_y = near(w.oxygen_y, 1100);
    w.hyd1_z = near(w.oxygen_z, 1100);
    w.hyd2_x = near(w.oxygen_x, 1100);
    w.hyd2_y = near(w.oxygen_y, 1100);
    w.hyd2_z = near(w.oxygen_z, 1100);
    return w;
  endfunction

  function automatic whb_in_t noise_water();
    whb_in_t      w;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(whb_in_t)-1:0];
    return w;
  endfunction

  task automatic directed_part();
    whb_in_t w;
    // textbook pair: donor H points straight at the acceptor oxygen
    w = '0; w.start_frame = 1'b1;
    w.hyd1_x = 20'sd1000; w.hyd2_y = 20'sd1000;
    send_water(w);
    w = '0; w.oxygen_x = 20'sd2900; w.hyd1_x = 20'sd3900; w.hyd2_y = 20'sd1000;
    w.hyd2_x = 20'sd2900;
    send_water(w);
    // same geometry across the periodic boundary
    w = '0; w.oxygen_x = 20'sd30000; w.hyd1_x = -20'sd30000; w.hyd2_x = 20'sd30000;
    w.hyd2_z = 20'sd900;
    send_water(w);
    // half box exactly: the difference flips sign
    w = '0; w.oxygen_y = 20'sd15360; w.hyd1_y = 20'sd0; w.hyd2_y = 20'sd30720;
    send_water(w);
    // coordinate extremes, saturating minimum image
    w = '0;
    w.oxygen_x = '1; w.oxygen_y = '1; w.oxygen_z = '1;
    {w.oxygen_x, w.oxygen_y, w.oxygen_z} = {3{20'h7FFFF}};
    {w.hyd1_x, w.hyd1_y, w.hyd1_z} = {3{20'h80000}};
    {w.hyd2_x, w.hyd2_y, w.hyd2_z} = {3{20'h7FFFF}};
    send_water(w);
    {w.oxygen_x, w.oxygen_y, w.oxygen_z} = {3{20'h80000}};
    {w.hyd1_x, w.hyd1_y, w.hyd1_z} = {3{20'h7FFFF}};
    {w.hyd2_x, w.hyd2_y, w.hyd2_z} = {3{20'h80000}};
    send_water(w);
    // coincident waters: zero O-O vector
    w = '0; send_water(w);
    w = '0; w.start_frame = 1'b1; send_water(w);
    w = '0; send_water(w);
    // all ones / all zeros patterns in every field
    w = '1; send_water(w);
    w = '0; w.start_frame = 1'b1; send_water(w);
  endtask

  initial begin
    int frame_len, cx, cy, cz;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();

    for (int p = 0; p < PhaseCount; p++) begin
      quiesce();
      load_setting(p);
      case (p % 4)
        0, 2: idle_pct = 0;
        1: idle_pct = 53;
        default: idle_pct = 23;
      endcase
      for (int n = 0; n < PhaseItems; ) begin
        if ($urandom_range(99) < 10) begin
          // noise and broken frames
          send_water(noise_water());
          n++;
        end else begin
          case ($urandom_range(19))
            0: frame_len = $urandom_range(64, 67);      // fills the store, then overflow
            1, 2, 3: frame_len = $urandom_range(13, 40);
            default: frame_len = $urandom_range(2, 12);
          endcase
          cx = $urandom_range(30720); cy = $urandom_range(30720); cz = $urandom_range(30720);
          for (int j = 0; j < frame_len; j++) begin
            send_water(cluster_water(j == 0, cx, cy, cz));
            n++;
          end
        end
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d waters sent, %0d rows checked: %0d with bonds, %0d overflow",
             sent, rows_seen, bonded_rows, overflow_rows);
    $display("%0d register settings including box and cutoff extremes", PhaseCount);
    if (err_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d rows missing", err_count, pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/whb_pkg.sv
rtl/whb_cell.sv
rtl/whb_pair_unit.sv
rtl/water_hbond_pair_detector.sv
tb/sv/whb_checker.sv
tb/sv/tb.sv
